// ===== hdl/mtrs_pkg.sv =====
package mtrs_pkg;

    // Session limits
    localparam int MAX_WINDOW_TILES = 64;
    localparam int MAX_WINDOWS      = 4;
    localparam int QIDX_W           = $clog2(MAX_WINDOWS);
    localparam int QCNT_W           = $clog2(MAX_WINDOWS + 1);
    localparam int TILE_IDX_W       = $clog2(MAX_WINDOW_TILES + 1);

    // Divider: 12-bit dividend, two quotient bits per cycle
    localparam int DIVIDEND_W = 12;
    localparam int DIVISOR_W  = 8;
    localparam int DIV_STEPS  = DIVIDEND_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // Input command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ENQUEUE = 2'd1;
    localparam logic [1:0] CMD_RESEND  = 2'd2;
    localparam logic [1:0] CMD_ACK     = 2'd3;

    // Result kind codes
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_FRAG     = 3'd1;
    localparam logic [2:0] KIND_ACK_REQ  = 3'd2;
    localparam logic [2:0] KIND_SESS_END = 3'd3;
    localparam logic [2:0] KIND_BAD_ACK  = 3'd4;

    // Ack that closes the session
    localparam logic       ACK_C_DONE = 1'b1;
    localparam logic [1:0] ACK_W_DONE = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_WINDOW_SIZE    = 3'd0;
    localparam logic [2:0] REG_WINDOW_COUNT   = 3'd1;
    localparam logic [2:0] REG_FULL_TILES     = 3'd2;
    localparam logic [2:0] REG_LINK_MTU       = 3'd3;
    localparam logic [2:0] REG_TILE_SIZE      = 3'd4;
    localparam logic [2:0] REG_CURRENT_WINDOW = 3'd5;

    typedef struct packed {
        logic [6:0]  window_size;
        logic [2:0]  window_count;
        logic [8:0]  full_tiles;
        logic [11:0] link_mtu;
        logic [7:0]  tile_size;
        logic [1:0]  current_window;
    } cfg_t;

    typedef struct packed {
        logic       wr_bitmap;
        logic       enqueue;
        logic       select;
        logic       div_start;
        logic       calc_used;
        logic       calc_mask;
        logic       calc_start;
        logic       calc_shift;
        logic       calc_run;
        logic       mark;
        logic       dequeue;
        logic       load_out;
        logic [2:0] out_kind;
        logic       out_again;
        logic       out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
        logic frag;
        logic missing;
        logic q_nonempty;
        logic q_one;
    } dp_status_t;

    // Mask of the first 'used' tiles of a window
    function automatic logic [MAX_WINDOW_TILES-1:0] used_mask(input logic [TILE_IDX_W-1:0] used);
        logic [MAX_WINDOW_TILES-1:0] m;
        if (used >= TILE_IDX_W'(MAX_WINDOW_TILES))
            m = '1;
        else
            m = (MAX_WINDOW_TILES'(1) << used[TILE_IDX_W-2:0]) - MAX_WINDOW_TILES'(1);
        return m;
    endfunction

    // Index of the lowest set bit, MAX_WINDOW_TILES when none is set
    function automatic logic [TILE_IDX_W-1:0] low_one(input logic [MAX_WINDOW_TILES-1:0] v);
        logic [TILE_IDX_W-1:0] r;
        r = TILE_IDX_W'(MAX_WINDOW_TILES);
        for (int i = MAX_WINDOW_TILES - 1; i >= 0; i--)
        begin
            if (v[i])
                r = TILE_IDX_W'(i);
        end
        return r;
    endfunction

endpackage

// ===== hdl/missing_tile_resend_selector_core.sv =====
// Load and enqueue items give no result.
// An ack item gives its result from the ACK state, once the result register is free.
// A resend step passes the states SEL, USED, MASK, START, SHIFT, RUN, MARK and CHECK; the
// radix-4 divider of frame size by tile size runs beside the bitmap scan.
// One item is worked at a time; ready returns once its results are queued.
// Reset: control cleared, bitmaps zero, registers to defaults, queue entries undefined.
module missing_tile_resend_selector_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         item_valid,
    output logic         item_ready,
    input  logic [1:0]   cmd,
    input  logic [1:0]   window,
    input  logic [63:0]  bitmap,
    input  logic         ack_c,
    input  logic [1:0]   ack_w,
    output logic         res_valid,
    input  logic         res_ready,
    output logic [2:0]   kind,
    output logic [1:0]   frag_window,
    output logic [5:0]   fcn,
    output logic [7:0]   first_tile,
    output logic [6:0]   tile_count,
    output logic         again,
    output logic         last
);

    mtrs_pkg::cfg_t       cfg;
    mtrs_pkg::ctrl_cmd_t  ctl;
    mtrs_pkg::dp_status_t status;

    mtrs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mtrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .ack_c      (ack_c),
        .ack_w      (ack_w),
        .status     (status),
        .ctl        (ctl)
    );

    mtrs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .status      (status),
        .cfg         (cfg),
        .window      (window),
        .bitmap      (bitmap),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .kind        (kind),
        .frag_window (frag_window),
        .fcn         (fcn),
        .first_tile  (first_tile),
        .tile_count  (tile_count),
        .again       (again),
        .last        (last)
    );

endmodule

// ===== hdl/mtrs_div.sv =====
module mtrs_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [mtrs_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [mtrs_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                busy,
    output logic [mtrs_pkg::DIVIDEND_W-1:0]     quotient
);

    logic [mtrs_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [mtrs_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [mtrs_pkg::DIVISOR_W:0]    rem_reg, rem_next;
    logic [mtrs_pkg::DIVISOR_W-1:0]  dsr_reg;
    logic [mtrs_pkg::DIVISOR_W:0]    r1, r2;
    logic                            ge1, ge2;

    // Two restoring steps per cycle, MSB first
    always_comb
    begin
        r1  = {rem_reg[mtrs_pkg::DIVISOR_W-1:0], quo_reg[mtrs_pkg::DIVIDEND_W-1]};
        ge1 = (r1 >= {1'b0, dsr_reg});
        if (ge1)
            r1 = r1 - {1'b0, dsr_reg};
        r2  = {r1[mtrs_pkg::DIVISOR_W-1:0], quo_reg[mtrs_pkg::DIVIDEND_W-2]};
        ge2 = (r2 >= {1'b0, dsr_reg});
        if (ge2)
            r2 = r2 - {1'b0, dsr_reg};
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = mtrs_pkg::DIV_CNT_W'(mtrs_pkg::DIV_STEPS);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - mtrs_pkg::DIV_CNT_W'(1);
            quo_next = {quo_reg[mtrs_pkg::DIVIDEND_W-3:0], ge1, ge2};
            rem_next = r2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            dsr_reg <= divisor;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

// ===== hdl/mtrs_regs.sv =====
module mtrs_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output mtrs_pkg::cfg_t       cfg
);

    mtrs_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_size    <= 7'd63;
            cfg_reg.window_count   <= 3'd4;
            cfg_reg.full_tiles     <= 9'd0;
            cfg_reg.link_mtu       <= 12'd51;
            cfg_reg.tile_size      <= 8'd10;
            cfg_reg.current_window <= 2'd0;
        end
        else if (wr_en)
        begin
            case (idx)
                mtrs_pkg::REG_WINDOW_SIZE:    cfg_reg.window_size    <= pwdata[6:0];
                mtrs_pkg::REG_WINDOW_COUNT:   cfg_reg.window_count   <= pwdata[2:0];
                mtrs_pkg::REG_FULL_TILES:     cfg_reg.full_tiles     <= pwdata[8:0];
                mtrs_pkg::REG_LINK_MTU:       cfg_reg.link_mtu       <= pwdata[11:0];
                mtrs_pkg::REG_TILE_SIZE:      cfg_reg.tile_size      <= pwdata[7:0];
                mtrs_pkg::REG_CURRENT_WINDOW: cfg_reg.current_window <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            mtrs_pkg::REG_WINDOW_SIZE:    prdata = 32'(cfg_reg.window_size);
            mtrs_pkg::REG_WINDOW_COUNT:   prdata = 32'(cfg_reg.window_count);
            mtrs_pkg::REG_FULL_TILES:     prdata = 32'(cfg_reg.full_tiles);
            mtrs_pkg::REG_LINK_MTU:       prdata = 32'(cfg_reg.link_mtu);
            mtrs_pkg::REG_TILE_SIZE:      prdata = 32'(cfg_reg.tile_size);
            mtrs_pkg::REG_CURRENT_WINDOW: prdata = 32'(cfg_reg.current_window);
            default:                      prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/mtrs_ctrl.sv =====
module mtrs_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic [1:0]              cmd,
    input  logic                    ack_c,
    input  logic [1:0]              ack_w,
    input  mtrs_pkg::dp_status_t    status,
    output mtrs_pkg::ctrl_cmd_t     ctl
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SEL   = 4'd1;
    localparam logic [3:0] ST_USED  = 4'd2;
    localparam logic [3:0] ST_MASK  = 4'd3;
    localparam logic [3:0] ST_START = 4'd4;
    localparam logic [3:0] ST_SHIFT = 4'd5;
    localparam logic [3:0] ST_RUN   = 4'd6;
    localparam logic [3:0] ST_MARK  = 4'd7;
    localparam logic [3:0] ST_CHECK = 4'd8;
    localparam logic [3:0] ST_EMIT1 = 4'd9;
    localparam logic [3:0] ST_EMIT2 = 4'd10;
    localparam logic [3:0] ST_ACK   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       again_reg, again_next;
    logic       last_reg, last_next;
    logic       ack_good_reg, ack_good_next;
    logic       accept;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    // Sequence one item and plan its results
    always_comb
    begin
        state_next    = state_reg;
        again_next    = again_reg;
        last_next     = last_reg;
        ack_good_next = ack_good_reg;
        ctl           = '0;
        ctl.out_kind  = mtrs_pkg::KIND_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        mtrs_pkg::CMD_LOAD:    ctl.wr_bitmap = 1'b1;
                        mtrs_pkg::CMD_ENQUEUE: ctl.enqueue = 1'b1;
                        mtrs_pkg::CMD_RESEND:  state_next = ST_SEL;
                        mtrs_pkg::CMD_ACK:
                        begin
                            ack_good_next = (ack_c == mtrs_pkg::ACK_C_DONE) &&
                                            (ack_w == mtrs_pkg::ACK_W_DONE);
                            state_next    = ST_ACK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEL:
            begin
                ctl.select    = 1'b1;
                ctl.div_start = 1'b1;
                state_next    = ST_USED;
            end
            ST_USED:
            begin
                ctl.calc_used = 1'b1;
                state_next    = ST_MASK;
            end
            ST_MASK:
            begin
                ctl.calc_mask = 1'b1;
                state_next    = ST_START;
            end
            ST_START:
            begin
                ctl.calc_start = 1'b1;
                state_next     = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                ctl.calc_shift = 1'b1;
                state_next     = ST_RUN;
            end
            ST_RUN:
            begin
                // Hold here until the capacity quotient is ready
                ctl.calc_run = 1'b1;
                if (!status.div_busy)
                    state_next = ST_MARK;
            end
            ST_MARK:
            begin
                ctl.mark   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.missing)
                begin
                    again_next = 1'b1;
                    last_next  = 1'b1;
                    state_next = status.frag ? ST_EMIT1 : ST_IDLE;
                end
                else if (status.q_nonempty)
                begin
                    ctl.dequeue = 1'b1;
                    if (status.q_one)
                    begin
                        again_next = 1'b0;
                        last_next  = 1'b0;
                        state_next = status.frag ? ST_EMIT1 : ST_EMIT2;
                    end
                    else
                    begin
                        again_next = 1'b1;
                        last_next  = 1'b1;
                        state_next = status.frag ? ST_EMIT1 : ST_IDLE;
                    end
                end
                else
                begin
                    again_next = 1'b0;
                    last_next  = 1'b1;
                    state_next = status.frag ? ST_EMIT1 : ST_IDLE;
                end
            end
            ST_EMIT1:
            begin
                if (status.out_free)
                begin
                    ctl.load_out  = 1'b1;
                    ctl.out_kind  = mtrs_pkg::KIND_FRAG;
                    ctl.out_again = again_reg;
                    ctl.out_last  = last_reg;
                    state_next    = last_reg ? ST_IDLE : ST_EMIT2;
                end
            end
            ST_EMIT2:
            begin
                if (status.out_free)
                begin
                    ctl.load_out = 1'b1;
                    ctl.out_kind = mtrs_pkg::KIND_ACK_REQ;
                    ctl.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ACK:
            begin
                if (status.out_free)
                begin
                    ctl.load_out = 1'b1;
                    ctl.out_kind = ack_good_reg ? mtrs_pkg::KIND_SESS_END
                                                : mtrs_pkg::KIND_BAD_ACK;
                    ctl.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        again_reg    <= again_next;
        last_reg     <= last_next;
        ack_good_reg <= ack_good_next;
    end

    // The quotient must be final before tiles are marked
    a_mark_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK) |-> !status.div_busy)
        else $error("marking started with the divider still busy");

endmodule

// ===== hdl/mtrs_dp.sv =====
module mtrs_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mtrs_pkg::ctrl_cmd_t     ctl,
    output mtrs_pkg::dp_status_t    status,
    input  mtrs_pkg::cfg_t          cfg,
    input  logic [1:0]              window,
    input  logic [63:0]             bitmap,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [2:0]              kind,
    output logic [1:0]              frag_window,
    output logic [5:0]              fcn,
    output logic [7:0]              first_tile,
    output logic [6:0]              tile_count,
    output logic                    again,
    output logic                    last
);

    localparam int NT = mtrs_pkg::MAX_WINDOW_TILES;
    localparam int TW = mtrs_pkg::TILE_IDX_W;
    localparam int QW = mtrs_pkg::QIDX_W;
    localparam int CW = mtrs_pkg::QCNT_W;

    // Window bitmaps and error window queue
    logic [NT-1:0]   bitmaps_reg [mtrs_pkg::MAX_WINDOWS];
    logic [1:0]      queue_mem [mtrs_pkg::MAX_WINDOWS];
    logic [QW-1:0]   head_reg;
    logic [CW-1:0]   count_reg;
    logic [1:0]      active_reg;

    // Scan pipeline
    logic [NT-1:0]   bm_reg;
    logic [TW-1:0]   used_reg;
    logic [NT-1:0]   zeros_reg;
    logic [TW-1:0]   start_reg;
    logic [NT-1:0]   shifted_reg;
    logic [TW-1:0]   run_reg;
    logic [NT-1:0]   newbm_reg;
    logic [TW-1:0]   n_reg;
    logic [5:0]      fcn_reg;
    logic [7:0]      first_reg;

    // Result register
    logic            res_valid_reg, res_valid_next;
    logic [2:0]      kind_reg;
    logic [1:0]      win_out_reg;
    logic [5:0]      fcn_out_reg;
    logic [7:0]      first_out_reg;
    logic [6:0]      count_out_reg;
    logic            again_reg;
    logic            last_reg;

    logic [mtrs_pkg::DIVIDEND_W-1:0] bytes;
    logic [mtrs_pkg::DIVISOR_W-1:0]  ts;
    logic [mtrs_pkg::DIVIDEND_W-1:0] cap;
    logic                            div_busy;

    logic [2:0]          wc_m1;
    logic                is_last_win;
    logic [9:0]          prod;
    logic signed [10:0]  diff;
    logic [TW-1:0]       used_calc;
    logic [TW-1:0]       n_calc;
    logic [NT-1:0]       fill;
    logic [NT-1:0]       newbm_calc;
    logic [8:0]          first_calc;
    logic [6:0]          fcn_calc;
    logic [QW-1:0]       tail;

    // Capacity in tiles per frame
    assign bytes = (cfg.link_mtu != '0) ? cfg.link_mtu - 12'd1 : '0;
    assign ts    = (cfg.tile_size != '0) ? cfg.tile_size : 8'd1;

    mtrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (bytes),
        .divisor  (ts),
        .busy     (div_busy),
        .quotient (cap)
    );

    // Used tiles of the active window, clamped to the window capacity
    always_comb
    begin
        wc_m1       = cfg.window_count - 3'd1;
        is_last_win = (cfg.window_count != '0) && ({1'b0, active_reg} == wc_m1);
        prod        = 10'(wc_m1) * 10'(cfg.window_size);
        diff        = $signed({2'b00, cfg.full_tiles}) - $signed({1'b0, prod});
        if (is_last_win)
        begin
            if (diff < 0)
                used_calc = '0;
            else if (diff > 11'sd64)
                used_calc = TW'(NT);
            else
                used_calc = diff[TW-1:0];
        end
        else
        begin
            if (cfg.window_size > 7'(NT))
                used_calc = TW'(NT);
            else
                used_calc = TW'(cfg.window_size);
        end
    end

    // Cap the run, mark its tiles and form the fragment header
    always_comb
    begin
        if ({{(mtrs_pkg::DIVIDEND_W-TW){1'b0}}, run_reg} > cap)
            n_calc = TW'(cap);
        else
            n_calc = run_reg;
        if (n_calc >= TW'(NT))
            fill = '1;
        else
            fill = (NT'(1) << n_calc[TW-2:0]) - NT'(1);
        newbm_calc = bm_reg | (fill << start_reg[TW-2:0]);
        fcn_calc   = cfg.window_size - 7'd1 - 7'(start_reg);
        first_calc = 9'(active_reg) * 9'(cfg.window_size) + 9'(start_reg);
    end

    assign tail = head_reg + count_reg[QW-1:0];

    // Control registers: queue pointers and active window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            active_reg <= '0;
        end
        else
        begin
            if (ctl.enqueue && (count_reg < CW'(mtrs_pkg::MAX_WINDOWS)))
                count_reg <= count_reg + CW'(1);
            if (ctl.dequeue)
            begin
                head_reg  <= head_reg + QW'(1);
                count_reg <= count_reg - CW'(1);
            end
            if (ctl.select && (count_reg != '0))
                active_reg <= queue_mem[head_reg];
        end
    end

    // Queue entries: written only, never cleared
    always_ff @(posedge clk)
    begin
        if (ctl.enqueue && (count_reg < CW'(mtrs_pkg::MAX_WINDOWS)))
            queue_mem[tail] <= window;
    end

    // Bitmaps: load from input, or merge the tiles just sent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mtrs_pkg::MAX_WINDOWS; i++)
                bitmaps_reg[i] <= '0;
        end
        else if (ctl.wr_bitmap)
            bitmaps_reg[window] <= bitmap;
        else if (ctl.mark)
            bitmaps_reg[active_reg] <= newbm_calc;
    end

    // Scan stages
    always_ff @(posedge clk)
    begin
        if (ctl.calc_used)
        begin
            used_reg <= used_calc;
            bm_reg   <= bitmaps_reg[active_reg];
        end
        if (ctl.calc_mask)
            zeros_reg <= ~bm_reg & mtrs_pkg::used_mask(used_reg);
        if (ctl.calc_start)
            start_reg <= mtrs_pkg::low_one(zeros_reg);
        if (ctl.calc_shift)
            shifted_reg <= zeros_reg >> start_reg[TW-2:0];
        if (ctl.calc_run)
            run_reg <= (zeros_reg == '0) ? '0 : mtrs_pkg::low_one(~shifted_reg);
        if (ctl.mark)
        begin
            newbm_reg <= newbm_calc;
            n_reg     <= n_calc;
            fcn_reg   <= fcn_calc[5:0];
            first_reg <= first_calc[7:0];
        end
    end

    assign status.div_busy   = div_busy;
    assign status.out_free   = !res_valid_reg || res_ready;
    assign status.frag       = (n_reg != '0);
    assign status.missing    = ((~newbm_reg & mtrs_pkg::used_mask(used_reg)) != '0);
    assign status.q_nonempty = (count_reg != '0);
    assign status.q_one      = (count_reg == CW'(1));

    // Result register: load on command, drop on transfer
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (ctl.load_out)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            kind_reg  <= ctl.out_kind;
            again_reg <= ctl.out_again;
            last_reg  <= ctl.out_last;
            if (ctl.out_kind == mtrs_pkg::KIND_FRAG)
            begin
                win_out_reg   <= active_reg;
                fcn_out_reg   <= fcn_reg;
                first_out_reg <= first_reg;
                count_out_reg <= 7'(n_reg);
            end
            else
            begin
                win_out_reg   <= (ctl.out_kind == mtrs_pkg::KIND_ACK_REQ) ?
                                 cfg.current_window : 2'd0;
                fcn_out_reg   <= '0;
                first_out_reg <= '0;
                count_out_reg <= '0;
            end
        end
    end

    assign res_valid   = res_valid_reg;
    assign kind        = kind_reg;
    assign frag_window = win_out_reg;
    assign fcn         = fcn_out_reg;
    assign first_tile  = first_out_reg;
    assign tile_count  = count_out_reg;
    assign again       = again_reg;
    assign last        = last_reg;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(mtrs_pkg::MAX_WINDOWS))
        else $error("error window queue overfilled");

    a_frag_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (kind_reg == mtrs_pkg::KIND_FRAG)) |-> (count_out_reg != '0))
        else $error("fragment with no tiles");

    a_ackreq_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (kind_reg == mtrs_pkg::KIND_ACK_REQ)) |-> last_reg)
        else $error("ack request not marked as last result");

endmodule

// ===== tb/sv/mtrs_reply_checker.sv =====
`timescale 1ns / 100ps

module mtrs_reply_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [1:0]  cmd,
    input  logic [1:0]  window,
    input  logic [63:0] bitmap,
    input  logic        ack_c,
    input  logic [1:0]  ack_w,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [2:0]  kind,
    input  logic [1:0]  frag_window,
    input  logic [5:0]  fcn,
    input  logic [7:0]  first_tile,
    input  logic [6:0]  tile_count,
    input  logic        again,
    input  logic        last,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] win;
        logic [5:0] fcn;
        logic [7:0] first;
        logic [6:0] count;
        logic       again;
        logic       last;
    } reply_t;

    // Shadow registers
    logic [6:0]  cfg_wsize  = 7'd63;
    logic [2:0]  cfg_wcount = 3'd4;
    logic [8:0]  cfg_full   = 9'd0;
    logic [11:0] cfg_mtu    = 12'd51;
    logic [7:0]  cfg_tsize  = 8'd10;
    logic [1:0]  cfg_cwin   = 2'd0;

    // Shadow session state
    logic [63:0] tiles [4];
    logic [1:0]  err_q [mtrs_pkg::MAX_WINDOWS];
    logic [1:0]  q_head;
    logic [2:0]  q_count;
    logic [1:0]  act_win;

    reply_t due_replies[$];
    int     bad_count;
    int     reply_no;

    function automatic reply_t mk_reply(logic [2:0] k, logic [1:0] w, logic [5:0] f,
                                        logic [7:0] t, logic [6:0] n, logic a, logic l);
        reply_t r;
        r.kind  = k;
        r.win   = w;
        r.fcn   = f;
        r.first = t;
        r.count = n;
        r.again = a;
        r.last  = l;
        return r;
    endfunction

    // Work out what one resend step sends and update the shadow bitmaps and FIFO
    task automatic plan_resend();
        int         used;
        int         gap_at;
        int         gap_len;
        int         cap;
        int         n;
        int         i;
        bit         holes;
        logic [5:0] f_fcn;
        logic [7:0] f_first;
        if (q_count != 0)
            act_win = err_q[q_head];
        if (cfg_wcount >= 1 && int'(act_win) == int'(cfg_wcount) - 1)
            used = int'(cfg_full) - (int'(cfg_wcount) - 1) * int'(cfg_wsize);
        else
            used = int'(cfg_wsize);
        if (used < 0)
            used = 0;
        if (used > mtrs_pkg::MAX_WINDOW_TILES)
            used = mtrs_pkg::MAX_WINDOW_TILES;

        // Find the first run of missing tiles
        gap_at = -1;
        gap_len = 0;
        for (i = 0; i < used; i++)
        begin
            if (!tiles[act_win][i])
            begin
                if (gap_at < 0)
                    gap_at = i;
                gap_len++;
            end
            else if (gap_at >= 0)
                break;
        end

        // Cap the run at what one frame carries
        cap = (cfg_mtu == 0 ? 0 : int'(cfg_mtu) - 1) / (cfg_tsize == 0 ? 1 : int'(cfg_tsize));
        n = (gap_len < cap) ? gap_len : cap;
        f_fcn = '0;
        f_first = '0;
        if (n != 0)
        begin
            f_fcn = 6'(int'(cfg_wsize) - 1 - gap_at);
            f_first = 8'(int'(act_win) * int'(cfg_wsize) + gap_at);
            for (i = gap_at; i < gap_at + n; i++)
                tiles[act_win][i] = 1'b1;
        end

        holes = 1'b0;
        for (i = 0; i < used; i++)
            if (!tiles[act_win][i])
                holes = 1'b1;

        if (holes)
        begin
            if (n != 0)
                due_replies.push_back(mk_reply(mtrs_pkg::KIND_FRAG, act_win, f_fcn, f_first,
                                               7'(n), 1'b1, 1'b1));
        end
        else if (q_count != 0)
        begin
            // Drop the clean window from the FIFO
            q_head = q_head + 2'd1;
            q_count = q_count - 3'd1;
            if (q_count == 0)
            begin
                if (n != 0)
                    due_replies.push_back(mk_reply(mtrs_pkg::KIND_FRAG, act_win, f_fcn,
                                                   f_first, 7'(n), 1'b0, 1'b0));
                due_replies.push_back(mk_reply(mtrs_pkg::KIND_ACK_REQ, cfg_cwin, '0, '0, '0,
                                               1'b0, 1'b1));
            end
            else if (n != 0)
                due_replies.push_back(mk_reply(mtrs_pkg::KIND_FRAG, act_win, f_fcn, f_first,
                                               7'(n), 1'b1, 1'b1));
        end
        else if (n != 0)
            due_replies.push_back(mk_reply(mtrs_pkg::KIND_FRAG, act_win, f_fcn, f_first,
                                           7'(n), 1'b0, 1'b1));
    endtask

    task automatic plan_item(logic [1:0] op, logic [1:0] win, logic [63:0] bits,
                             logic chk, logic [1:0] wfield);
        case (op)
            mtrs_pkg::CMD_LOAD:
                tiles[win] = bits;
            mtrs_pkg::CMD_ENQUEUE:
            begin
                // A full FIFO ignores the transfer
                if (q_count < mtrs_pkg::MAX_WINDOWS)
                begin
                    err_q[2'(q_head + q_count)] = win;
                    q_count = q_count + 3'd1;
                end
            end
            mtrs_pkg::CMD_ACK:
            begin
                if (chk == mtrs_pkg::ACK_C_DONE && wfield == mtrs_pkg::ACK_W_DONE)
                    due_replies.push_back(mk_reply(mtrs_pkg::KIND_SESS_END, '0, '0, '0, '0,
                                                   1'b0, 1'b1));
                else
                    due_replies.push_back(mk_reply(mtrs_pkg::KIND_BAD_ACK, '0, '0, '0, '0,
                                                   1'b0, 1'b1));
            end
            default:
                plan_resend();
        endcase
    endtask

    task automatic take_config(logic [2:0] idx, logic [31:0] val);
        case (idx)
            mtrs_pkg::REG_WINDOW_SIZE:    cfg_wsize  = val[6:0];
            mtrs_pkg::REG_WINDOW_COUNT:   cfg_wcount = val[2:0];
            mtrs_pkg::REG_FULL_TILES:     cfg_full   = val[8:0];
            mtrs_pkg::REG_LINK_MTU:       cfg_mtu    = val[11:0];
            mtrs_pkg::REG_TILE_SIZE:      cfg_tsize  = val[7:0];
            mtrs_pkg::REG_CURRENT_WINDOW: cfg_cwin   = val[1:0];
            default: ;
        endcase
    endtask

    task automatic check_reply();
        reply_t got;
        reply_t want;
        got = mk_reply(kind, frag_window, fcn, first_tile, tile_count, again, last);
        if (due_replies.size() == 0)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("%0t: result %0d expected none, actual kind=%0d win=%0d fcn=%0d",
                         $time, reply_no, got.kind, got.win, got.fcn);
        end
        else
        begin
            want = due_replies.pop_front();
            if (got !== want)
            begin
                bad_count++;
                if (bad_count <= 10)
                begin
                    $display("%0t: result %0d mismatch", $time, reply_no);
                    $display("  expected kind=%0d win=%0d fcn=%0d first=%0d",
                             want.kind, want.win, want.fcn, want.first);
                    $display("           count=%0d again=%0d last=%0d",
                             want.count, want.again, want.last);
                    $display("  actual   kind=%0d win=%0d fcn=%0d first=%0d",
                             got.kind, got.win, got.fcn, got.first);
                    $display("           count=%0d again=%0d last=%0d",
                             got.count, got.again, got.last);
                end
            end
        end
        reply_no++;
    endtask

    // Follow register writes, item transfers and result transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_wsize  = 7'd63;
            cfg_wcount = 3'd4;
            cfg_full   = 9'd0;
            cfg_mtu    = 12'd51;
            cfg_tsize  = 8'd10;
            cfg_cwin   = 2'd0;
            for (int w = 0; w < 4; w++)
                tiles[w] = '0;
            q_head = '0;
            q_count = '0;
            act_win = '0;
            due_replies.delete();
            bad_count = 0;
            reply_no = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                take_config(paddr[4:2], pwdata);
            if (item_valid && item_ready)
                plan_item(cmd, window, bitmap, ack_c, ack_w);
            if (res_valid && res_ready)
                check_reply();
            pending <= due_replies.size();
            fail_count <= bad_count;
        end
    end

endmodule

// ===== tb/sv/tb_missing_tile_resend_selector_core.sv =====
`timescale 1ns / 100ps

module tb_missing_tile_resend_selector_core;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 160;
    localparam int SETTLE_CYCLES = 30;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [4:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  cmd        = mtrs_pkg::CMD_LOAD;
    logic [1:0]  window     = '0;
    logic [63:0] bitmap     = '0;
    logic        ack_c      = 1'b0;
    logic [1:0]  ack_w      = '0;
    logic        res_valid;
    logic        res_ready  = 1'b0;
    logic [2:0]  kind;
    logic [1:0]  frag_window;
    logic [5:0]  fcn;
    logic [7:0]  first_tile;
    logic [6:0]  tile_count;
    logic        again;
    logic        last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    int stall_mode  = 0;
    int sess_wcount = 4;

    always #5 clk = ~clk;

    missing_tile_resend_selector_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .cmd         (cmd),
        .window      (window),
        .bitmap      (bitmap),
        .ack_c       (ack_c),
        .ack_w       (ack_w),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .kind        (kind),
        .frag_window (frag_window),
        .fcn         (fcn),
        .first_tile  (first_tile),
        .tile_count  (tile_count),
        .again       (again),
        .last        (last)
    );

    mtrs_reply_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .cmd         (cmd),
        .window      (window),
        .bitmap      (bitmap),
        .ack_c       (ack_c),
        .ack_w       (ack_w),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .kind        (kind),
        .frag_window (frag_window),
        .fcn         (fcn),
        .first_tile  (first_tile),
        .tile_count  (tile_count),
        .again       (again),
        .last        (last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Stall the result channel on a changing pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 80);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0: res_ready <= 1'b1;
            1: res_ready <= ($urandom_range(0, 1) == 1);
            2: res_ready <= ($urandom_range(0, 3) == 0);
            default: res_ready <= ((stall_left % 8) < 2);
        endcase
    end

    // Abort a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(int ws, int wc, int ft, int mtu, int ts, int cw);
        write_reg(mtrs_pkg::REG_WINDOW_SIZE, 32'(ws));
        write_reg(mtrs_pkg::REG_WINDOW_COUNT, 32'(wc));
        write_reg(mtrs_pkg::REG_FULL_TILES, 32'(ft));
        write_reg(mtrs_pkg::REG_LINK_MTU, 32'(mtu));
        write_reg(mtrs_pkg::REG_TILE_SIZE, 32'(ts));
        write_reg(mtrs_pkg::REG_CURRENT_WINDOW, 32'(cw));
        sess_wcount = wc;
        @(posedge clk);
    endtask

    // Hold the sender until every expected result has come
    task automatic wait_drained();
        item_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Send one item, opening a new burst after a random gap when the last one ran out
    task automatic put_item(logic [1:0] op, logic [1:0] win, logic [63:0] bits,
                            logic chk, logic [1:0] wfield);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        cmd        <= op;
        window     <= win;
        bitmap     <= bits;
        ack_c      <= chk;
        ack_w      <= wfield;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [63:0] rand_bitmap();
        logic [63:0] v;
        int          lo;
        int          len;
        case ($urandom_range(0, 6))
            0: v = '1;
            1: v = {$urandom, $urandom};
            2, 3, 4:
            begin
                // Mostly received, one run of holes and maybe a stray one
                v = '1;
                lo = $urandom_range(0, 63);
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    if (lo + i < 64)
                        v[lo + i] = 1'b0;
                if ($urandom_range(0, 1) == 1)
                    v[$urandom_range(0, 63)] = 1'b0;
            end
            5: v = '0;
            default: v = {$urandom, $urandom} | {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic rand_item();
        put_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand_bitmap(),
                 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    endtask

    // Load bitmaps, queue error windows, step resends and close with an ack
    task automatic run_session();
        int  k;
        int  n_enq;
        int  n_steps;
        logic [1:0] win;
        for (k = 0; k < 4; k++)
            put_item(mtrs_pkg::CMD_LOAD, 2'(k), rand_bitmap(), 1'($urandom_range(0, 1)),
                     2'($urandom_range(0, 3)));
        n_enq = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(1, 4);
        for (k = 0; k < n_enq; k++)
        begin
            if ($urandom_range(0, 4) == 0)
                win = 2'($urandom_range(0, 3));
            else
                win = 2'($urandom_range(0, sess_wcount - 1));
            put_item(mtrs_pkg::CMD_ENQUEUE, win, {$urandom, $urandom},
                     1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        end
        n_steps = $urandom_range(1, 16);
        for (k = 0; k < n_steps; k++)
        begin
            put_item(mtrs_pkg::CMD_RESEND, 2'($urandom_range(0, 3)), {$urandom, $urandom},
                     1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 19) == 0)
                rand_item();
        end
        if ($urandom_range(0, 3) != 0)
            put_item(mtrs_pkg::CMD_ACK, 2'($urandom_range(0, 3)), {$urandom, $urandom},
                     mtrs_pkg::ACK_C_DONE, mtrs_pkg::ACK_W_DONE);
        else
            put_item(mtrs_pkg::CMD_ACK, 2'($urandom_range(0, 3)), {$urandom, $urandom},
                     1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 11) == 0)
            wait_drained();
    endtask

    // Short fixed sequence: ack codes, resend with an empty FIFO, full FIFO, clean windows
    task automatic run_directed();
        int k;
        put_item(mtrs_pkg::CMD_ACK, 2'd0, '0, 1'b1, 2'd3);
        put_item(mtrs_pkg::CMD_ACK, 2'd3, '1, 1'b0, 2'd3);
        put_item(mtrs_pkg::CMD_ACK, 2'd1, '0, 1'b1, 2'd0);
        // Empty FIFO: work on window 0 in place until it is clean
        for (k = 0; k < 3; k++)
            put_item(mtrs_pkg::CMD_RESEND, 2'd0, '0, 1'b0, 2'd0);
        put_item(mtrs_pkg::CMD_LOAD, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'd0);
        put_item(mtrs_pkg::CMD_LOAD, 2'd1, 64'h0000_0000_0000_0000, 1'b1, 2'd3);
        put_item(mtrs_pkg::CMD_LOAD, 2'd2, 64'hFFFF_FFFF_FFFF_FF5A, 1'b0, 2'd1);
        put_item(mtrs_pkg::CMD_LOAD, 2'd3, 64'hFFFF_FFFF_FFFF_FFC0, 1'b1, 2'd2);
        // Fifth enqueue hits a full FIFO
        for (k = 0; k < 4; k++)
            put_item(mtrs_pkg::CMD_ENQUEUE, 2'(k), '0, 1'b0, 2'd0);
        put_item(mtrs_pkg::CMD_ENQUEUE, 2'd1, '1, 1'b1, 2'd3);
        for (k = 0; k < 10; k++)
            put_item(mtrs_pkg::CMD_RESEND, 2'(k), '0, 1'b0, 2'd0);
    endtask

    task automatic choose_setting(int p);
        int ws;
        int wc;
        int ft;
        case (p)
            1: apply_setting(64, 4, 256, 2048, 1, 3);
            2: apply_setting(1, 1, 0, 2, 255, 0);
            3: apply_setting(16, 4, 20, 31, 3, 1);
            4: apply_setting(32, 2, 50, 2, 1, 2);
            5: apply_setting(10, 3, 25, 100, 0, 3);
            6: apply_setting(20, 4, 70, 1, 5, 0);
            7: apply_setting(12, 4, 40, 0, 7, 1);
            8: apply_setting(5, 1, 200, 300, 7, 1);
            default:
            begin
                ws = $urandom_range(1, 64);
                wc = $urandom_range(1, 4);
                ft = (wc - 1) * ws + $urandom_range(0, ws);
                if (ft > 256)
                    ft = 256;
                apply_setting(ws, wc, ft, $urandom_range(2, 160), $urandom_range(1, 24),
                              $urandom_range(0, 3));
            end
        endcase
    endtask

    initial
    begin
        int p;
        int phase_base;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);
        apply_setting(8, 4, 30, 21, 4, 2);
        run_directed();

        // Random phases, each under its own register setting
        for (p = 1; p < NUM_PHASES; p++)
        begin
            settle();
            choose_setting(p);
            phase_base = items_sent;
            while (items_sent - phase_base < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 6) == 0)
                    rand_item();
                else
                    run_session();
            end
        end

        settle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
